### hdl/rdms_pkg.sv
// Shared types and constants for the randomized depth-first maze solver.
// No dependencies; imported by the solver top level and its checker.
`default_nettype none
package rdms_pkg;

	localparam int MAX_SIDE   = 32;
	localparam int CELLS      = MAX_SIDE * MAX_SIDE;
	localparam int CELL_AW    = $clog2(CELLS);
	localparam int COORD_W    = $clog2(MAX_SIDE);
	localparam int SIDE_W     = 6;
	localparam int LEN_W      = CELL_AW + 1;
	localparam int RAND_W     = 8;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 6;

	typedef enum logic [1:0] {
		REQ_WALL    = 2'd0,
		REQ_RESTART = 2'd1,
		REQ_STEP    = 2'd2,
		REQ_NONE    = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		STS_ACK       = 3'd0,
		STS_ADVANCED  = 3'd1,
		STS_BACKTRACK = 3'd2,
		STS_GOAL      = 3'd3,
		STS_NO_PATH   = 3'd4,
		STS_EXHAUSTED = 3'd5,
		STS_FINISHED  = 3'd6
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GRID_SIZE = 3'd0,
		CFG_START_ROW = 3'd1,
		CFG_START_COL = 3'd2,
		CFG_GOAL_ROW  = 3'd3,
		CFG_GOAL_COL  = 3'd4
	} cfg_idx_t;

endpackage
`default_nettype wire

### hdl/rdms_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module rdms_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

### hdl/random_dfs_maze_solver_step.sv
// Randomized depth-first maze solver, top level.
// Depends on rdms_pkg and rdms_ram (wall map, visited map, path stack).
//
// Usage:
//   Requests arrive on the s_ stream: s_tuser carries the request kind (wall
//   write, restart, step), s_tdata the wall cell, wall bit and random value.
//   Every request gives exactly one result transfer on the m_ stream: status
//   in m_tuser, path head and path length in m_tdata. Registers are written
//   through cfg_we/cfg_index/cfg_data while the block is idle.
//   One request is worked on at a time; s_tready is high only when idle.
//   A wall write or the unused kind goes straight to the output cycle; a step
//   does too when finished or exhausted, else it runs one visited write, a
//   neighbor scan through the wall and visited memories, a decision cycle, an
//   optional path-stack read on backtrack, and an output cycle. A restart
//   first runs the sweep that clears the visited memory one cell per cycle.
//   After reset a sweep clears the wall and visited memories;
//   s_tready stays low during it, configuration writes are taken.
//   The result sits in an output register; a stalled receiver holds the
//   block in its output cycle only once that register is still occupied.
`default_nettype none
module random_dfs_maze_solver_step (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	// [4:0] cell_row, [9:5] cell_col, [10] wall_bit, [18:11] rand_value, rest zero
	input  wire logic [rdms_pkg::IN_DATA_W-1:0]       s_tdata,
	// [1:0] req_type
	input  wire logic [1:0]                           s_tuser,
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	// [4:0] head_row, [9:5] head_col, [20:10] path_length, rest zero
	output logic      [rdms_pkg::OUT_DATA_W-1:0]      m_tdata,
	// [2:0] status
	output logic      [2:0]                           m_tuser,
	input  wire logic                                 cfg_we,
	input  wire logic [rdms_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [rdms_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import rdms_pkg::*;

	typedef enum logic [2:0] {
		ST_CLR, ST_IDLE, ST_STEP, ST_SCAN, ST_DECIDE, ST_POP, ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		DIR_ROW_UP = 2'd0, DIR_COL_UP = 2'd1, DIR_ROW_DN = 2'd2, DIR_COL_DN = 2'd3
	} dir_t;

	function automatic logic [1:0] mod3(input logic [RAND_W-1:0] v);
		logic [3:0] s;
		logic [2:0] t;
		s = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[7:6]);
		t = 3'(s[1:0]) + 3'(s[3:2]);
		if (t >= 3'd6) begin
			mod3 = 2'(t - 3'd6);
		end else if (t >= 3'd3) begin
			mod3 = 2'(t - 3'd3);
		end else begin
			mod3 = t[1:0];
		end
	endfunction

	state_t              st_q;
	logic [SIDE_W-1:0]   grid_size_q;
	logic [COORD_W-1:0]  start_row_q, start_col_q, goal_row_q, goal_col_q;
	logic [LEN_W-1:0]    count_q, dead_q;
	logic                done_q;
	logic [CELL_AW-1:0]  top_q;
	logic [CELL_AW-1:0]  clr_idx_q;
	logic                clr_wall_q;
	logic [RAND_W-1:0]   rand_q;
	logic [2:0]          k_q;
	logic [2:0]          n_q;
	logic [CELL_AW-1:0]  nb_list_q [4];
	logic                chk_s1, inb_s1;
	logic [CELL_AW-1:0]  cell_s1;
	status_t             res_q;
	logic                m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;
	logic [2:0]          m_tuser_q;

	logic                s_xfer;
	logic [SIDE_W-1:0]   gs;
	logic [11:0]         area, used;
	logic [COORD_W-1:0]  head_row, head_col;
	logic [SIDE_W-1:0]   nr6, nc6;
	logic                nb_inb;
	logic [1:0]          pick;
	logic [CELL_AW-1:0]  cand;
	logic [LEN_W-1:0]    pop_addr;
	logic                push_ok;

	logic                wall_we, wall_wd, wall_rd;
	logic [CELL_AW-1:0]  wall_waddr, nb_addr;
	logic                vis_we, vis_wd, vis_rd;
	logic [CELL_AW-1:0]  vis_waddr;
	logic                stk_we;
	logic [CELL_AW-1:0]  stk_rd;

	assign s_tready = (st_q == ST_IDLE);
	assign s_xfer   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	assign gs   = (grid_size_q > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : grid_size_q;
	assign area = 12'(gs * gs);
	assign used = 12'(dead_q) + 12'(count_q);

	assign head_row = (count_q == '0) ? start_row_q : top_q[CELL_AW-1:COORD_W];
	assign head_col = (count_q == '0) ? start_col_q : top_q[COORD_W-1:0];

	always_comb begin
		nr6 = {1'b0, head_row};
		nc6 = {1'b0, head_col};
		case (dir_t'(k_q[1:0]))
			DIR_ROW_UP: nr6 = {1'b0, head_row} + SIDE_W'(1);
			DIR_COL_UP: nc6 = {1'b0, head_col} + SIDE_W'(1);
			DIR_ROW_DN: nr6 = {1'b0, head_row} - SIDE_W'(1);
			DIR_COL_DN: nc6 = {1'b0, head_col} - SIDE_W'(1);
			default: ;
		endcase
	end
	assign nb_inb  = (nr6 < gs) && (nc6 < gs);
	assign nb_addr = {nr6[COORD_W-1:0], nc6[COORD_W-1:0]};

	always_comb begin
		case (n_q)
			3'd2:    pick = {1'b0, rand_q[0]};
			3'd3:    pick = mod3(rand_q);
			3'd4:    pick = rand_q[1:0];
			default: pick = 2'd0;
		endcase
	end
	assign cand     = nb_list_q[pick];
	assign push_ok  = (n_q != 3'd0) && (cand != {goal_row_q, goal_col_q})
		&& (count_q < LEN_W'(CELLS));
	assign pop_addr = count_q - LEN_W'(2);

	// memory port control
	always_comb begin
		wall_we    = 1'b0;
		wall_waddr = {s_tdata[COORD_W-1:0], s_tdata[2*COORD_W-1:COORD_W]};
		wall_wd    = s_tdata[2*COORD_W];
		if (st_q == ST_CLR) begin
			wall_we    = clr_wall_q;
			wall_waddr = clr_idx_q;
			wall_wd    = 1'b0;
		end else if (s_xfer && req_t'(s_tuser) == REQ_WALL) begin
			wall_we = 1'b1;
		end

		vis_we    = 1'b0;
		vis_waddr = cand;
		vis_wd    = 1'b1;
		case (st_q)
			ST_CLR: begin
				vis_we    = 1'b1;
				vis_waddr = clr_idx_q;
				vis_wd    = 1'b0;
			end
			ST_STEP: begin
				vis_we    = !done_q && (used < area);
				vis_waddr = {start_row_q, start_col_q};
			end
			ST_DECIDE: vis_we = push_ok;
			default: ;
		endcase

		stk_we = (st_q == ST_DECIDE) && push_ok;
	end

	rdms_ram #(.WIDTH(1), .DEPTH(CELLS)) u_wall (
		.clk   (clk),
		.we    (wall_we),
		.waddr (wall_waddr),
		.wdata (wall_wd),
		.raddr (nb_addr),
		.rdata (wall_rd)
	);

	rdms_ram #(.WIDTH(1), .DEPTH(CELLS)) u_visited (
		.clk   (clk),
		.we    (vis_we),
		.waddr (vis_waddr),
		.wdata (vis_wd),
		.raddr (nb_addr),
		.rdata (vis_rd)
	);

	rdms_ram #(.WIDTH(CELL_AW), .DEPTH(CELLS)) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (count_q[CELL_AW-1:0]),
		.wdata (cand),
		.raddr (pop_addr[CELL_AW-1:0]),
		.rdata (stk_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_size_q <= SIDE_W'(MAX_SIDE);
			start_row_q <= '0;
			start_col_q <= '0;
			goal_row_q  <= COORD_W'(MAX_SIDE - 1);
			goal_col_q  <= COORD_W'(MAX_SIDE - 1);
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_GRID_SIZE: grid_size_q <= cfg_data;
				CFG_START_ROW: start_row_q <= cfg_data[COORD_W-1:0];
				CFG_START_COL: start_col_q <= cfg_data[COORD_W-1:0];
				CFG_GOAL_ROW:  goal_row_q  <= cfg_data[COORD_W-1:0];
				CFG_GOAL_COL:  goal_col_q  <= cfg_data[COORD_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_CLR;
			clr_idx_q  <= '0;
			clr_wall_q <= 1'b1;
			count_q    <= '0;
			dead_q     <= '0;
			done_q     <= 1'b0;
			k_q        <= '0;
			n_q        <= '0;
			chk_s1     <= 1'b0;
			res_q      <= STS_ACK;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready && st_q != ST_EMIT) begin
				m_tvalid_q <= 1'b0;
			end
			case (st_q)
				ST_CLR: begin
					clr_idx_q <= clr_idx_q + CELL_AW'(1);
					if (clr_idx_q == CELL_AW'(CELLS - 1)) begin
						st_q <= clr_wall_q ? ST_IDLE : ST_EMIT;
					end
				end
				ST_IDLE: begin
					if (s_xfer) begin
						rand_q <= s_tdata[2*COORD_W+1 +: RAND_W];
						res_q  <= STS_ACK;
						case (req_t'(s_tuser))
							REQ_RESTART: begin
								count_q    <= '0;
								dead_q     <= '0;
								done_q     <= 1'b0;
								clr_idx_q  <= '0;
								clr_wall_q <= 1'b0;
								st_q       <= ST_CLR;
							end
							REQ_STEP: st_q <= ST_STEP;
							default:  st_q <= ST_EMIT;
						endcase
					end
				end
				ST_STEP: begin
					k_q    <= '0;
					n_q    <= '0;
					chk_s1 <= 1'b0;
					if (done_q) begin
						res_q <= STS_FINISHED;
						st_q  <= ST_EMIT;
					end else if (used >= area) begin
						done_q <= 1'b1;
						res_q  <= STS_EXHAUSTED;
						st_q   <= ST_EMIT;
					end else begin
						st_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (chk_s1 && inb_s1 && !wall_rd && !vis_rd) begin
						nb_list_q[n_q[1:0]] <= cell_s1;
						n_q <= n_q + 3'd1;
					end
					chk_s1  <= (k_q != 3'd4);
					inb_s1  <= nb_inb;
					cell_s1 <= nb_addr;
					k_q     <= k_q + 3'd1;
					if (k_q == 3'd4) begin
						st_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					st_q <= ST_EMIT;
					if (n_q != 3'd0) begin
						if (cand == {goal_row_q, goal_col_q}) begin
							done_q <= 1'b1;
							res_q  <= STS_GOAL;
						end else if (!push_ok) begin
							done_q <= 1'b1;
							res_q  <= STS_EXHAUSTED;
						end else begin
							top_q   <= cand;
							count_q <= count_q + LEN_W'(1);
							res_q   <= STS_ADVANCED;
						end
					end else if (count_q != '0) begin
						count_q <= count_q - LEN_W'(1);
						dead_q  <= dead_q + LEN_W'(1);
						res_q   <= STS_BACKTRACK;
						if (count_q > LEN_W'(1)) begin
							st_q <= ST_POP;
						end
					end else begin
						done_q <= 1'b1;
						res_q  <= STS_NO_PATH;
					end
				end
				ST_POP: begin
					top_q <= stk_rd;
					st_q  <= ST_EMIT;
				end
				ST_EMIT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tuser_q  <= res_q;
						m_tdata_q  <= OUT_DATA_W'({count_q, head_col, head_row});
						st_q       <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

### hdl/rdms_chk.sv
// Port-level checker for the maze solver, bound to the top level.
// Depends on rdms_pkg.
`default_nettype none
module rdms_chk (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            s_tvalid,
	input wire logic                            s_tready,
	input wire logic [rdms_pkg::IN_DATA_W-1:0]  s_tdata,
	input wire logic [1:0]                      s_tuser,
	input wire logic                            m_tvalid,
	input wire logic                            m_tready,
	input wire logic [rdms_pkg::OUT_DATA_W-1:0] m_tdata,
	input wire logic [2:0]                      m_tuser
);
	import rdms_pkg::*;

	logic [LEN_W-1:0] out_len;
	assign out_len = m_tdata[2*COORD_W +: LEN_W];

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while another is in work");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser != 3'd7 && out_len <= LEN_W'(CELLS))
		else $error("bad status or path length");

	a_advance_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == STS_ADVANCED |-> out_len != '0)
		else $error("advance with empty path");

endmodule

bind random_dfs_maze_solver_step rdms_chk u_rdms_chk (.*);
`default_nettype wire
